// ----- rtl/pwbd_pkg.sv -----
// Package: shared constants and types of the pulse width bit decoder and framer.
package pwbd_pkg;

   localparam int FRAME_BITS       = 12;
   localparam int HIGH_NIBBLE_BITS = 4;
   localparam int COUNT_WIDTH      = $clog2(FRAME_BITS + 1);
   localparam int BYTE_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH  = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PULSE_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_PULSE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE        = 2'd2;

   localparam logic [BYTE_WIDTH-1:0] BIT_PULSE_LIMIT_RESET   = 8'd15;
   localparam logic [BYTE_WIDTH-1:0] START_PULSE_LIMIT_RESET = 8'd50;
   localparam logic [BYTE_WIDTH-1:0] START_BYTE_RESET        = 8'hE5;

   typedef enum logic [1:0] {
      SLOT_START = 2'd0,
      SLOT_HIGH  = 2'd1,
      SLOT_LOW   = 2'd2,
      SLOT_CHECK = 2'd3
   } slot_type;

   typedef struct packed {
      logic                  load;
      logic [BYTE_WIDTH-1:0] start_byte;
      logic [BYTE_WIDTH-1:0] frame_high;
      logic [BYTE_WIDTH-1:0] frame_low;
      logic [BYTE_WIDTH-1:0] check_byte;
   } telegram_type;

endpackage

// ----- rtl/pwbd_if.sv -----
// Interfaces: pulse transaction channel and telegram byte channel.
interface pwbd_req_if;
   import pwbd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] pulse_width;
   logic                  pin_level;

   modport source (output valid, output pulse_width, output pin_level, input ready);
   modport sink   (input valid, input pulse_width, input pin_level, output ready);
endinterface

interface pwbd_rsp_if;
   import pwbd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] out_byte;
   logic                  last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ----- rtl/pwbd_decoder.sv -----
// Decoder: limit registers, frame shift registers, bit count and telegram build.
module pwbd_decoder
   import pwbd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [BYTE_WIDTH-1:0]      pulse_width,
   input  logic                       pin_level,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_write_data,
   output logic                       near_full,
   output telegram_type               telegram
);

   logic [BYTE_WIDTH-1:0]  bit_limit_ff, start_limit_ff, start_byte_ff;
   logic [BYTE_WIDTH-1:0]  high_ff, high_in, low_ff, low_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   data_bit, is_data, is_start, shift_en, complete;
   logic [BYTE_WIDTH-1:0]  sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_limit_ff   <= BIT_PULSE_LIMIT_RESET;
         start_limit_ff <= START_PULSE_LIMIT_RESET;
         start_byte_ff  <= START_BYTE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIT_PULSE_LIMIT:   bit_limit_ff   <= csr_write_data;
            CSR_START_PULSE_LIMIT: start_limit_ff <= csr_write_data;
            CSR_START_BYTE:        start_byte_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign data_bit = ~pin_level;
   assign is_data  = pulse_width < bit_limit_ff;
   assign is_start = !is_data && (pulse_width > start_limit_ff);
   assign shift_en = accept && is_data && (count_ff < COUNT_WIDTH'(FRAME_BITS));

   always_comb begin
      high_in  = high_ff;
      low_in   = low_ff;
      count_in = count_ff;
      if (shift_en) begin
         if (count_ff < COUNT_WIDTH'(HIGH_NIBBLE_BITS)) begin
            high_in = {high_ff[BYTE_WIDTH-2:0], data_bit};
         end else begin
            low_in = {low_ff[BYTE_WIDTH-2:0], data_bit};
         end
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (accept && is_start) begin
         high_in  = {{(BYTE_WIDTH-1){1'b0}}, data_bit};
         low_in   = '0;
         count_in = '0;
      end
   end

   assign complete = shift_en && (count_in == COUNT_WIDTH'(FRAME_BITS));
   assign sum      = start_byte_ff + high_in + low_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= '0;
         low_ff   <= '0;
         count_ff <= '0;
      end else begin
         high_ff  <= high_in;
         low_ff   <= low_in;
         count_ff <= count_in;
      end
   end

   assign near_full           = count_ff == COUNT_WIDTH'(FRAME_BITS - 1);
   assign telegram.load       = complete;
   assign telegram.start_byte = start_byte_ff;
   assign telegram.frame_high = high_in;
   assign telegram.frame_low  = low_in;
   assign telegram.check_byte = BYTE_WIDTH'(0) - sum;

endmodule

// ----- rtl/pwbd_serializer.sv -----
// Serialiser: telegram result register and byte sequencer.
module pwbd_serializer
   import pwbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  telegram_type          telegram,
   input  logic                  take,
   output logic                  busy,
   output logic [BYTE_WIDTH-1:0] out_byte,
   output logic                  last
);

   logic [BYTE_WIDTH-1:0] start_ff, high_ff, low_ff, check_ff;
   slot_type              slot_ff, slot_in;
   logic                  busy_ff, busy_in;

   always_ff @(posedge clock) begin
      if (telegram.load) begin
         start_ff <= telegram.start_byte;
         high_ff  <= telegram.frame_high;
         low_ff   <= telegram.frame_low;
         check_ff <= telegram.check_byte;
      end
   end

   always_comb begin
      slot_in = slot_ff;
      busy_in = busy_ff;
      if (telegram.load) begin
         slot_in = SLOT_START;
         busy_in = 1'b1;
      end else if (take) begin
         if (slot_ff == SLOT_CHECK) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_type'(slot_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_START;
         busy_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      case (slot_ff)
         SLOT_START: out_byte = start_ff;
         SLOT_HIGH:  out_byte = high_ff;
         SLOT_LOW:   out_byte = low_ff;
         SLOT_CHECK: out_byte = check_ff;
         default:    out_byte = start_ff;
      endcase
   end

   assign busy = busy_ff;
   assign last = slot_ff == SLOT_CHECK;

endmodule

// ----- rtl/pulse_width_bit_decoder_framer.sv -----
// Top level: pulse width bit decoder and telegram framer.
// Latency: the start byte of a telegram is shown the cycle after the pulse that completes
// the frame is accepted; the four bytes follow at one per cycle while the sink takes them.
// Throughput: one pulse transaction per cycle; the input stalls only while a telegram is
// still draining and the frame lacks one bit, since the serialiser holds one telegram.
// Reset: synchronous, active high; clears the frame and count, restores limits and start byte.
module pulse_width_bit_decoder_framer
   import pwbd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   pwbd_req_if.sink                   req_chan,
   pwbd_rsp_if.source                 rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_write_data
);

   logic         accept;
   logic         near_full;
   logic         busy;
   logic         take;
   telegram_type telegram;

   // Hold off pulses only when one more data bit could complete a frame while the
   // previous telegram still occupies the serialiser.
   assign req_chan.ready = !(busy && near_full);
   assign accept         = req_chan.valid && req_chan.ready;
   assign take           = rsp_chan.valid && rsp_chan.ready;

   // Decode the pulse, advance the frame and build the telegram in the accepting cycle.
   pwbd_decoder u_decoder (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .pulse_width      (req_chan.pulse_width),
      .pin_level        (req_chan.pin_level),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .near_full        (near_full),
      .telegram         (telegram)
   );

   // Register the telegram and hand its bytes out one transaction at a time.
   pwbd_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .telegram (telegram),
      .take     (take),
      .busy     (busy),
      .out_byte (rsp_chan.out_byte),
      .last     (rsp_chan.last)
   );

   assign rsp_chan.valid = busy;

endmodule

// ----- rtl/pwbd_checker.sv -----
// Checker: port level assertions on the framer, bound to the top level.
module pwbd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   // A stalled telegram byte stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Input back-pressure only arises from a telegram still draining.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no telegram pending");

   // A telegram never stops before its checksum byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("telegram cut short");

   // Telegrams never run back to back without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("telegram follows checksum without gap");

endmodule

bind pulse_width_bit_decoder_framer pwbd_checker u_pwbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last)
);

// ----- tb/sv/pwbd_telegram_checker.sv -----
// Checker: predicts the telegram bytes of accepted pulses and compares them with the byte channel.
module pwbd_telegram_checker
   import pwbd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   pwbd_req_if                        req_mon,
   pwbd_rsp_if                        rsp_mon,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_write_data,
   output int                         mismatch_count,
   output int                         bytes_pending,
   output int                         bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 24;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] value;
      logic                  last;
   } telegram_byte_type;

   telegram_byte_type expected_bytes[$];

   logic [BYTE_WIDTH-1:0]  bit_limit;
   logic [BYTE_WIDTH-1:0]  start_limit;
   logic [BYTE_WIDTH-1:0]  lead_byte;
   logic [BYTE_WIDTH-1:0]  high_shift;
   logic [BYTE_WIDTH-1:0]  low_shift;
   logic [COUNT_WIDTH-1:0] bits_seen;
   int                     errors;
   int                     checked;

   // Decode one pulse: shift a bit in or restart the frame; queue the telegram when it fills.
   task automatic decode_pulse(input logic [BYTE_WIDTH-1:0] width, input logic pin);
      logic                  data_bit;
      logic [BYTE_WIDTH-1:0] sum;
      data_bit = ~pin;
      if (width < bit_limit) begin
         if (bits_seen < FRAME_BITS) begin
            if (bits_seen < HIGH_NIBBLE_BITS)
               high_shift = {high_shift[BYTE_WIDTH-2:0], data_bit};
            else
               low_shift = {low_shift[BYTE_WIDTH-2:0], data_bit};
            bits_seen = bits_seen + 1'b1;
            if (bits_seen == FRAME_BITS) begin
               sum = lead_byte + high_shift + low_shift;
               expected_bytes.push_back('{lead_byte, 1'b0});
               expected_bytes.push_back('{high_shift, 1'b0});
               expected_bytes.push_back('{low_shift, 1'b0});
               expected_bytes.push_back('{8'd0 - sum, 1'b1});
            end
         end
      end else if (width > start_limit) begin
         high_shift = {{(BYTE_WIDTH-1){1'b0}}, data_bit};
         low_shift  = '0;
         bits_seen  = '0;
      end
   endtask

   always @(posedge clock) begin
      telegram_byte_type seen;
      telegram_byte_type want;
      if (reset) begin
         bit_limit   = BIT_PULSE_LIMIT_RESET;
         start_limit = START_PULSE_LIMIT_RESET;
         lead_byte   = START_BYTE_RESET;
         high_shift  = '0;
         low_shift   = '0;
         bits_seen   = '0;
         errors      = 0;
         checked     = 0;
         expected_bytes.delete();
      end else begin
         // compare first, so a byte can never match an expectation queued at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.out_byte, rsp_mon.last};
            if (expected_bytes.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected telegram byte: expected none, actual %02h last %0b",
                           $time, seen.value, seen.last);
            end else begin
               want = expected_bytes.pop_front();
               checked++;
               if (seen.value !== want.value) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                              $time, want.value, seen.value);
               end
               if (seen.last !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: last mismatch: expected %0b, actual %0b",
                              $time, want.last, seen.last);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BIT_PULSE_LIMIT:   bit_limit   = csr_write_data;
               CSR_START_PULSE_LIMIT: start_limit = csr_write_data;
               CSR_START_BYTE:        lead_byte   = csr_write_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            decode_pulse(req_mon.pulse_width, req_mon.pin_level);
      end
      mismatch_count <= errors;
      bytes_checked  <= checked;
      bytes_pending  <= expected_bytes.size();
   end

endmodule

// ----- tb/sv/tb_pulse_width_bit_decoder_framer.sv -----
// Testbench top: drives pulse transactions and register writes, and gives the verdict.
module tb_pulse_width_bit_decoder_framer
   import pwbd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MAX_SINK_STALL = 12;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int PHASE_COUNT    = 7;

   // index with no register behind it; writes to it must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_CHOPPY,
      SINK_STALLING
   } sink_mode_type;

   typedef struct {
      logic [BYTE_WIDTH-1:0] bit_limit;
      logic [BYTE_WIDTH-1:0] start_limit;
      logic [BYTE_WIDTH-1:0] lead_byte;
      int                    pulses;
   } pulse_setting_type;

   // Register settings visited after the directed part. Cover both extremes of every
   // register, limits that overlap, and settings where starts or bits cannot occur.
   pulse_setting_type settings[PHASE_COUNT] = '{
      '{8'd8,   8'd20,  8'h00, 50},
      '{8'd255, 8'd254, 8'hFF, 50},
      '{8'd100, 8'd20,  8'h5A, 50},
      '{8'd0,   8'd0,   8'h81, 20},
      '{8'd40,  8'd255, 8'hC3, 25},
      '{8'd1,   8'd1,   8'h3C, 45},
      '{BIT_PULSE_LIMIT_RESET, START_PULSE_LIMIT_RESET, START_BYTE_RESET, 50}
   };

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [BYTE_WIDTH-1:0]      csr_write_data;

   pwbd_req_if req_chan();
   pwbd_rsp_if rsp_chan();

   int mismatch_count;
   int bytes_pending;
   int bytes_checked;

   // sender state
   logic                  req_active = 1'b0;
   int                    burst_left = 0;
   int                    pulses_sent = 0;
   int                    settings_applied = 0;
   logic [BYTE_WIDTH-1:0] cur_bit_limit = BIT_PULSE_LIMIT_RESET;
   logic [BYTE_WIDTH-1:0] cur_start_limit = START_PULSE_LIMIT_RESET;

   // receiver state
   sink_mode_type sink_mode = SINK_OPEN;
   int            sink_timer = 0;
   int            sink_hold = 0;
   int            cycle_count = 0;

   pulse_width_bit_decoder_framer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pwbd_telegram_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .bytes_pending    (bytes_pending),
      .bytes_checked    (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Guard against a hung handshake: drop out with a failure once the budget is spent.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d telegram bytes still owed",
                  cycle_count, bytes_pending);
         $display("pulse_width_bit_decoder_framer verification failed");
         $finish;
      end
   end

   // Receiver: switch at random between always ready, coin-toss ready and random stalls,
   // so back-pressure lands on every byte slot of a telegram.
   always @(posedge clock) begin
      if (sink_hold != 0) begin
         rsp_chan.ready <= 1'b0;
         sink_hold <= sink_hold - 1;
      end else begin
         case (sink_mode)
            SINK_OPEN: begin
               rsp_chan.ready <= 1'b1;
            end
            SINK_CHOPPY: begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_chan.ready <= 1'b1;
               if ($urandom_range(0, 4) == 0)
                  sink_hold <= $urandom_range(1, MAX_SINK_STALL);
            end
         endcase
      end
      if (sink_timer == 0) begin
         sink_mode  <= sink_mode_type'($urandom_range(0, 2));
         sink_timer <= $urandom_range(16, 96);
      end else begin
         sink_timer <= sink_timer - 1;
      end
   end

   // Offer one pulse transaction and hold it until the block takes it. Within a burst
   // valid stays high and the next call only swaps the payload; at the end of a burst
   // drop valid for a random gap.
   task automatic send_pulse(input logic [BYTE_WIDTH-1:0] width, input logic pin);
      req_chan.valid       <= 1'b1;
      req_chan.pulse_width <= width;
      req_chan.pin_level   <= pin;
      req_active = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      pulses_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid <= 1'b0;
         req_active = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      end
   endtask

   // Stop offering pulses and wait until every predicted byte has come out, then let
   // the block settle in case an accepted pulse is still being absorbed.
   task automatic drain_telegrams();
      if (req_active) begin
         req_chan.valid <= 1'b0;
         req_active = 1'b0;
      end
      do @(posedge clock); while (bytes_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [BYTE_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Load a full register setting, then poke the unused index with junk that would
   // show up in the telegrams if the block decoded it as a real register.
   task automatic apply_setting(input pulse_setting_type s);
      write_register(CSR_BIT_PULSE_LIMIT, s.bit_limit);
      write_register(CSR_START_PULSE_LIMIT, s.start_limit);
      write_register(CSR_START_BYTE, s.lead_byte);
      write_register(CSR_UNUSED, 8'($urandom_range(0, 255)));
      csr_write_enable <= 1'b0;
      cur_bit_limit   = s.bit_limit;
      cur_start_limit = s.start_limit;
      settings_applied++;
   endtask

   // Data bit width under the current limits, any width if none can; favour the edges.
   function automatic logic [BYTE_WIDTH-1:0] data_width();
      if (cur_bit_limit == 0)
         return 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0)
         return ($urandom_range(0, 1) != 0) ? 8'd0 : cur_bit_limit - 8'd1;
      return 8'($urandom_range(0, cur_bit_limit - 1));
   endfunction

   // Restart width: above the start limit, not a data bit; any width if none can.
   function automatic logic [BYTE_WIDTH-1:0] start_width();
      int lo;
      if (cur_start_limit == 8'd255)
         return 8'($urandom_range(0, 255));
      lo = (int'(cur_start_limit) + 1 > int'(cur_bit_limit)) ? int'(cur_start_limit) + 1
                                                            : int'(cur_bit_limit);
      if ($urandom_range(0, 3) == 0)
         return ($urandom_range(0, 1) != 0) ? 8'(lo) : 8'd255;
      return 8'($urandom_range(lo, 255));
   endfunction

   // Width between the limits, which the block must ignore; any width if they overlap.
   function automatic logic [BYTE_WIDTH-1:0] ignored_width();
      if (cur_bit_limit > cur_start_limit)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(cur_bit_limit, cur_start_limit));
   endfunction

   // Mostly whole frames with random bits, some overfull ones that must saturate,
   // some cut short by the next start, and the rest plain noise.
   task automatic run_random(input int count);
      int done;
      int pick;
      int frame_bits;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            if (pick < 70)
               frame_bits = FRAME_BITS + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            else
               frame_bits = $urandom_range(1, FRAME_BITS - 1);
            send_pulse(start_width(), 1'($urandom_range(0, 1)));
            done++;
            for (int i = 0; i < frame_bits; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_pulse(ignored_width(), 1'($urandom_range(0, 1)));
                  done++;
               end
               send_pulse(data_width(), 1'($urandom_range(0, 1)));
               done++;
            end
         end else begin
            send_pulse(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            done++;
         end
      end
   endtask

   initial begin
      logic [FRAME_BITS-1:0] pin_pattern;

      // hold every input the sender owns at a known value from time zero
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_BIT_PULSE_LIMIT;
      csr_write_data       <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.pulse_width <= '0;
      req_chan.pin_level   <= 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limits. Fill a frame without any start pulse,
      // alternating the narrowest and the widest data width.
      pin_pattern = 12'b1010_0110_1100;
      for (int i = 0; i < FRAME_BITS; i++)
         send_pulse((i % 2 == 0) ? 8'd0 : BIT_PULSE_LIMIT_RESET - 8'd1, pin_pattern[i]);
      // a bit after a full frame must be dropped
      send_pulse(8'd7, 1'b0);
      // widths exactly at either limit are neither bits nor starts
      send_pulse(BIT_PULSE_LIMIT_RESET, 1'b1);
      send_pulse(START_PULSE_LIMIT_RESET, 1'b0);
      // narrowest and widest start pulses, each seeding the high byte with its bit
      send_pulse(START_PULSE_LIMIT_RESET + 8'd1, 1'b1);
      send_pulse(8'd255, 1'b0);
      for (int i = 0; i < 7; i++)
         send_pulse(8'(i + 1), 1'(i % 2));
      drain_telegrams();

      // Random part: one phase per register setting, drained before each rewrite.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_setting(settings[p]);
         @(posedge clock);
         run_random(settings[p].pulses);
         drain_telegrams();
      end

      $display("Covered %0d pulse transactions across reset and %0d register settings;",
               pulses_sent, settings_applied);
      $display("%0d telegram bytes compared under mixed back-pressure.", bytes_checked);
      if (mismatch_count == 0 && bytes_pending == 0)
         $display("pulse_width_bit_decoder_framer verification clean");
      else
         $display("pulse_width_bit_decoder_framer verification failed");
      $finish;
   end

endmodule
